>>> hw/rtl/assert_macros.svh
// Assertion helper macros shared by checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> hw/rtl/tae_pkg.sv
// ----------------------------------------------------------------------------
// tae_pkg
// Shared types and constants of the compressed-ISA execute block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package tae_pkg;

  localparam logic [3:0] KIND_LO_ADD  = 4'd0;
  localparam logic [3:0] KIND_LO_SUB  = 4'd1;
  localparam logic [3:0] KIND_MOV_IMM = 4'd2;
  localparam logic [3:0] KIND_CMP_IMM = 4'd3;
  localparam logic [3:0] KIND_ADD_IMM = 4'd4;
  localparam logic [3:0] KIND_SUB_IMM = 4'd5;
  localparam logic [3:0] KIND_HI_ADD  = 4'd6;
  localparam logic [3:0] KIND_HI_CMP  = 4'd7;
  localparam logic [3:0] KIND_HI_MOV  = 4'd8;
  localparam logic [3:0] KIND_SP_ADDR = 4'd9;
  localparam logic [3:0] KIND_PC_ADDR = 4'd10;
  localparam logic [3:0] KIND_SP_ADJ  = 4'd11;
  localparam logic [3:0] KIND_ALU     = 4'd12;

  // ALU opcodes in instruction bits 9..6.
  localparam logic [3:0] ALU_AND = 4'd0;
  localparam logic [3:0] ALU_EOR = 4'd1;
  localparam logic [3:0] ALU_LSL = 4'd2;
  localparam logic [3:0] ALU_LSR = 4'd3;
  localparam logic [3:0] ALU_ASR = 4'd4;
  localparam logic [3:0] ALU_ADC = 4'd5;
  localparam logic [3:0] ALU_SBC = 4'd6;
  localparam logic [3:0] ALU_ROR = 4'd7;
  localparam logic [3:0] ALU_TST = 4'd8;
  localparam logic [3:0] ALU_NEG = 4'd9;
  localparam logic [3:0] ALU_CMP = 4'd10;
  localparam logic [3:0] ALU_CMN = 4'd11;
  localparam logic [3:0] ALU_ORR = 4'd12;
  localparam logic [3:0] ALU_MUL = 4'd13;
  localparam logic [3:0] ALU_BIC = 4'd14;
  localparam logic [3:0] ALU_MVN = 4'd15;

  localparam logic [3:0] REG_SP = 4'd13;
  localparam logic [3:0] REG_PC = 4'd15;

  // Operation class chosen by the front end.
  typedef enum logic [4:0] {
    OP_NOP, OP_ADD, OP_SUB, OP_ADC, OP_SBC, OP_MOVNZ, OP_PASS, OP_AND, OP_EOR,
    OP_ORR, OP_BIC, OP_MVN, OP_LSL, OP_LSR, OP_ASR, OP_ROR, OP_MUL, OP_UNDEF
  } op_e;

  // Decoded request handed from front to back.
  typedef struct packed {
    op_e         op;
    logic [3:0]  ra;      // first operand register
    logic [3:0]  rb;      // second operand register
    logic        b_imm;   // second operand is the immediate
    logic [31:0] imm;
    logic        a_sp;    // first operand is SP
    logic        a_pcal;  // first operand is PC aligned to a word
    logic        a_zero;  // first operand is zero
    logic        we;
    logic [3:0]  rd;
  } dec_t;

endpackage

>>> hw/rtl/tae_front.sv
// ----------------------------------------------------------------------------
// tae_front
// Classifies one instruction into an operation, operand selects and a write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tae_front (
  input  logic [3:0]      kind_i,
  input  logic [15:0]     instruction_i,
  output tae_pkg::dec_t   dec_o
);
  logic [2:0] r3a, r3b, r3c, rh;
  logic       h1, h2;
  logic [3:0] hd, hs;
  logic [31:0] imm8, imm8x4;

  assign r3a = instruction_i[2:0];
  assign r3b = instruction_i[5:3];
  assign r3c = instruction_i[8:6];
  assign rh  = instruction_i[10:8];
  assign h1  = instruction_i[7];
  assign h2  = instruction_i[6];
  assign hd  = {h1, r3a};
  assign hs  = {h2, r3b};
  assign imm8   = {24'd0, instruction_i[7:0]};
  assign imm8x4 = {22'd0, instruction_i[7:0], 2'b00};

  // Format decoder.
  always_comb begin
    dec_o = '0;
    dec_o.op = tae_pkg::OP_NOP;
    unique case (kind_i)
      tae_pkg::KIND_LO_ADD, tae_pkg::KIND_LO_SUB: begin
        dec_o.op = (kind_i == tae_pkg::KIND_LO_ADD) ? tae_pkg::OP_ADD : tae_pkg::OP_SUB;
        dec_o.ra = {1'b0, r3b};
        dec_o.rb = {1'b0, r3c};
        dec_o.b_imm = instruction_i[10];
        dec_o.imm = {29'd0, r3c};
        dec_o.we = 1'b1;
        dec_o.rd = {1'b0, r3a};
      end
      tae_pkg::KIND_MOV_IMM: begin
        dec_o.op = tae_pkg::OP_MOVNZ;
        dec_o.b_imm = 1'b1;
        dec_o.imm = imm8;
        dec_o.we = 1'b1;
        dec_o.rd = {1'b0, rh};
      end
      tae_pkg::KIND_CMP_IMM, tae_pkg::KIND_ADD_IMM, tae_pkg::KIND_SUB_IMM: begin
        dec_o.op = (kind_i == tae_pkg::KIND_ADD_IMM) ? tae_pkg::OP_ADD : tae_pkg::OP_SUB;
        dec_o.ra = {1'b0, rh};
        dec_o.b_imm = 1'b1;
        dec_o.imm = imm8;
        dec_o.we = (kind_i != tae_pkg::KIND_CMP_IMM);
        dec_o.rd = {1'b0, rh};
      end
      tae_pkg::KIND_HI_ADD, tae_pkg::KIND_HI_CMP, tae_pkg::KIND_HI_MOV: begin
        dec_o.ra = hd;
        dec_o.rb = hs;
        dec_o.rd = hd;
        if (!(h1 | h2)) begin
          dec_o.op = tae_pkg::OP_UNDEF;
        end else if (kind_i == tae_pkg::KIND_HI_CMP) begin
          dec_o.op = tae_pkg::OP_SUB;
        end else begin
          dec_o.op = tae_pkg::OP_PASS;
          dec_o.we = 1'b1;
          // MOV passes Rs by adding zero.
          if (kind_i == tae_pkg::KIND_HI_MOV) begin
            dec_o.b_imm = 1'b1;
            dec_o.ra = hs;
          end
        end
      end
      tae_pkg::KIND_SP_ADDR, tae_pkg::KIND_PC_ADDR: begin
        dec_o.op = tae_pkg::OP_PASS;
        dec_o.a_sp = (kind_i == tae_pkg::KIND_SP_ADDR);
        dec_o.a_pcal = (kind_i == tae_pkg::KIND_PC_ADDR);
        dec_o.b_imm = 1'b1;
        dec_o.imm = imm8x4;
        dec_o.we = 1'b1;
        dec_o.rd = {1'b0, rh};
      end
      tae_pkg::KIND_SP_ADJ: begin
        dec_o.op = tae_pkg::OP_PASS;
        dec_o.a_sp = 1'b1;
        dec_o.b_imm = 1'b1;
        dec_o.imm = h1 ? (32'd0 - {23'd0, instruction_i[6:0], 2'b00})
                       : {23'd0, instruction_i[6:0], 2'b00};
        dec_o.we = 1'b1;
        dec_o.rd = tae_pkg::REG_SP;
      end
      tae_pkg::KIND_ALU: begin
        dec_o.ra = {1'b0, r3a};
        dec_o.rb = {1'b0, r3b};
        dec_o.rd = {1'b0, r3a};
        dec_o.we = 1'b1;
        unique case (instruction_i[9:6])
          tae_pkg::ALU_AND: dec_o.op = tae_pkg::OP_AND;
          tae_pkg::ALU_EOR: dec_o.op = tae_pkg::OP_EOR;
          tae_pkg::ALU_LSL: dec_o.op = tae_pkg::OP_LSL;
          tae_pkg::ALU_LSR: dec_o.op = tae_pkg::OP_LSR;
          tae_pkg::ALU_ASR: dec_o.op = tae_pkg::OP_ASR;
          tae_pkg::ALU_ADC: dec_o.op = tae_pkg::OP_ADC;
          tae_pkg::ALU_SBC: dec_o.op = tae_pkg::OP_SBC;
          tae_pkg::ALU_ROR: dec_o.op = tae_pkg::OP_ROR;
          tae_pkg::ALU_TST: begin dec_o.op = tae_pkg::OP_AND; dec_o.we = 1'b0; end
          tae_pkg::ALU_NEG: begin
            // NEG: zero minus Rs.
            dec_o.op = tae_pkg::OP_SUB;
            dec_o.a_zero = 1'b1;
          end
          tae_pkg::ALU_CMP: begin dec_o.op = tae_pkg::OP_SUB; dec_o.we = 1'b0; end
          tae_pkg::ALU_CMN: begin dec_o.op = tae_pkg::OP_ADD; dec_o.we = 1'b0; end
          tae_pkg::ALU_ORR: dec_o.op = tae_pkg::OP_ORR;
          tae_pkg::ALU_MUL: dec_o.op = tae_pkg::OP_MUL;
          tae_pkg::ALU_BIC: dec_o.op = tae_pkg::OP_BIC;
          default: dec_o.op = tae_pkg::OP_MVN;
        endcase
      end
      default: dec_o.op = tae_pkg::OP_NOP;
    endcase
  end
endmodule

>>> hw/rtl/tae_queue.sv
// ----------------------------------------------------------------------------
// tae_queue
// Two-entry queue of decoded requests between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tae_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tae_pkg::dec_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output tae_pkg::dec_t data_o
);
  tae_pkg::dec_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rp_q];

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= data_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= ~wp_q;
      if (do_pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule

>>> hw/rtl/tae_back.sv
// ----------------------------------------------------------------------------
// tae_back
// Executes decoded requests against the register file and flags, and holds
// the results in a two-entry output buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tae_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  tae_pkg::dec_t dec_i,
  output logic          take_o,
  input  logic          pop_i,
  output logic          empty_o,
  output logic          write_enable_o,
  output logic [3:0]    dest_index_o,
  output logic [31:0]   dest_value_o,
  output logic          flag_negative_o,
  output logic          flag_zero_o,
  output logic          flag_carry_o,
  output logic          flag_overflow_o,
  output logic          reload_pipeline_o,
  output logic          undefined_op_o
);
  typedef struct packed {
    logic        we;
    logic [3:0]  di;
    logic [31:0] dv;
    logic [3:0]  nzcv;
    logic        rl;
    logic        ud;
  } res_t;

  logic [31:0] rf_q [16];
  logic [3:0]  nzcv_q;
  res_t        ob_q [2];
  logic        ow_q, or_q;
  logic [1:0]  ocnt_q;
  logic        go, do_pop;

  logic [31:0] a, b, r;
  logic [32:0] s;
  logic        cin, c, v, sub;
  logic [7:0]  n;
  logic [4:0]  m;
  logic [63:0] ext;
  logic        logic_nz;
  res_t        res;
  logic [3:0]  nzcv_d;

  assign do_pop  = pop_i && !empty_o;
  assign empty_o = (ocnt_q == 2'd0);
  assign go      = valid_i && (ocnt_q != 2'd2);
  assign take_o  = go;

  // Operand selection.
  always_comb begin
    a = rf_q[dec_i.ra];
    if (dec_i.a_sp) a = rf_q[tae_pkg::REG_SP];
    if (dec_i.a_pcal) a = rf_q[tae_pkg::REG_PC] & 32'hFFFF_FFFC;
    if (dec_i.a_zero) a = 32'd0;
    b = dec_i.b_imm ? dec_i.imm : rf_q[dec_i.rb];
  end

  // Arithmetic, logic and shifts.
  always_comb begin
    sub = (dec_i.op == tae_pkg::OP_SUB) || (dec_i.op == tae_pkg::OP_SBC);
    cin = 1'b0;
    if (dec_i.op == tae_pkg::OP_SUB) cin = 1'b1;
    if (dec_i.op == tae_pkg::OP_ADC || dec_i.op == tae_pkg::OP_SBC) cin = nzcv_q[1];
    s = {1'b0, a} + {1'b0, sub ? ~b : b} + {32'd0, cin};
    n = b[7:0];
    m = n[4:0];
    c = nzcv_q[1];
    v = nzcv_q[0];
    r = a;
    logic_nz = 1'b1;
    ext = 64'd0;
    case (dec_i.op)
      tae_pkg::OP_ADD, tae_pkg::OP_ADC, tae_pkg::OP_SUB, tae_pkg::OP_SBC: begin
        r = s[31:0];
        c = s[32];
        v = sub ? ((a[31] ^ b[31]) & (a[31] ^ r[31]))
                : (~(a[31] ^ b[31]) & (a[31] ^ r[31]));
      end
      tae_pkg::OP_PASS: begin
        r = s[31:0];
        logic_nz = 1'b0;
      end
      tae_pkg::OP_MOVNZ: r = b;
      tae_pkg::OP_AND:   r = a & b;
      tae_pkg::OP_EOR:   r = a ^ b;
      tae_pkg::OP_ORR:   r = a | b;
      tae_pkg::OP_BIC:   r = a & ~b;
      tae_pkg::OP_MVN:   r = ~b;
      tae_pkg::OP_MUL:   r = a * b;
      tae_pkg::OP_LSL: begin
        ext = {32'd0, a} << n[5:0];
        if (n == 8'd0) r = a;
        else if (n < 8'd33) begin r = ext[31:0]; c = ext[32]; end
        else begin r = 32'd0; c = 1'b0; end
      end
      tae_pkg::OP_LSR: begin
        ext = {a, 32'd0} >> n[5:0];
        if (n == 8'd0) r = a;
        else if (n < 8'd33) begin r = ext[63:32]; c = ext[31]; end
        else begin r = 32'd0; c = 1'b0; end
      end
      tae_pkg::OP_ASR: begin
        ext = $signed({a, 32'd0}) >>> n[4:0];
        if (n == 8'd0) r = a;
        else if (n < 8'd32) begin r = ext[63:32]; c = ext[31]; end
        else begin r = {32{a[31]}}; c = a[31]; end
      end
      tae_pkg::OP_ROR: begin
        ext = {a, a} >> m;
        if (n == 8'd0) r = a;
        else if (m == 5'd0) c = a[31];
        else begin r = ext[31:0]; c = r[31]; end
      end
      default: logic_nz = 1'b0;
    endcase
    nzcv_d = nzcv_q;
    if (logic_nz) nzcv_d = {r[31], r == 32'd0, c, v};
    res = '0;
    res.ud = (dec_i.op == tae_pkg::OP_UNDEF);
    if (dec_i.we) begin
      res.we = 1'b1;
      res.di = dec_i.rd;
      res.dv = r;
      if (dec_i.rd == tae_pkg::REG_PC && dec_i.op == tae_pkg::OP_PASS && !dec_i.a_sp
          && !dec_i.a_pcal) begin
        res.dv = {r[31:1], 1'b0};
        res.rl = 1'b1;
      end
    end
    res.nzcv = nzcv_d;
  end

  // Register file update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) rf_q[i] <= 32'd0;
      nzcv_q <= 4'd0;
    end else if (go) begin
      if (res.we) rf_q[res.di] <= res.dv;
      nzcv_q <= nzcv_d;
    end
  end

  // Result buffer storage.
  always_ff @(posedge clk_i) begin
    if (go) ob_q[ow_q] <= res;
  end

  // Result buffer pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ow_q <= 1'b0;
      or_q <= 1'b0;
      ocnt_q <= 2'd0;
    end else begin
      if (go) ow_q <= ~ow_q;
      if (do_pop) or_q <= ~or_q;
      ocnt_q <= ocnt_q + {1'b0, go} - {1'b0, do_pop};
    end
  end

  assign write_enable_o    = ob_q[or_q].we;
  assign dest_index_o      = ob_q[or_q].di;
  assign dest_value_o      = ob_q[or_q].dv;
  assign flag_negative_o   = ob_q[or_q].nzcv[3];
  assign flag_zero_o       = ob_q[or_q].nzcv[2];
  assign flag_carry_o      = ob_q[or_q].nzcv[1];
  assign flag_overflow_o   = ob_q[or_q].nzcv[0];
  assign reload_pipeline_o = ob_q[or_q].rl;
  assign undefined_op_o    = ob_q[or_q].ud;
endmodule

>>> hw/rtl/thumb_alu_execute.sv
// ----------------------------------------------------------------------------
// thumb_alu_execute
// Execute stage for 16-bit compressed-ISA data-processing instructions.
// ----------------------------------------------------------------------------
// Each instruction pushed is decoded by the front end in the same cycle and
// written into a two-entry request queue; the back end reads the register
// file, runs one ALU pass, updates registers and flags and parks the result
// in a two-entry output buffer. One instruction per cycle is sustained while
// neither buffer is full; a result is held in the queue, then the output
// buffer, before the result ports; the combinational ALU pass with its 32x32
// multiplier sets the clock period. No clearing pass is needed after reset.
`timescale 1ns / 1ps
module thumb_alu_execute (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [3:0]  kind_i,
  input  logic [15:0] instruction_i,
  output logic        empty,
  input  logic        pop,
  output logic        write_enable_o,
  output logic [3:0]  dest_index_o,
  output logic [31:0] dest_value_o,
  output logic        flag_negative_o,
  output logic        flag_zero_o,
  output logic        flag_carry_o,
  output logic        flag_overflow_o,
  output logic        reload_pipeline_o,
  output logic        undefined_op_o
);
  tae_pkg::dec_t dec_in, dec_out;
  logic q_empty, take;

  tae_front u_front (
    .kind_i(kind_i), .instruction_i(instruction_i), .dec_o(dec_in)
  );

  tae_queue u_queue (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(push), .data_i(dec_in), .full_o(full),
    .pop_i(take), .empty_o(q_empty), .data_o(dec_out)
  );

  tae_back u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(!q_empty), .dec_i(dec_out),
    .take_o(take), .pop_i(pop), .empty_o(empty),
    .write_enable_o(write_enable_o), .dest_index_o(dest_index_o),
    .dest_value_o(dest_value_o), .flag_negative_o(flag_negative_o),
    .flag_zero_o(flag_zero_o), .flag_carry_o(flag_carry_o),
    .flag_overflow_o(flag_overflow_o), .reload_pipeline_o(reload_pipeline_o),
    .undefined_op_o(undefined_op_o)
  );
endmodule

>>> hw/rtl/tae_checker.sv
// ----------------------------------------------------------------------------
// tae_checker
// Port-level checks of the execute block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tae_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic        write_enable_o,
  input logic [3:0]  dest_index_o,
  input logic [31:0] dest_value_o,
  input logic        reload_pipeline_o,
  input logic        undefined_op_o
);
  logic pc_write;

  // A write to the program counter with bit 0 clear.
  assign pc_write = write_enable_o && (dest_index_o == tae_pkg::REG_PC) && !dest_value_o[0];

  // A waiting result stays until it is taken.
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(dest_value_o))
  // Reload only comes with a write to the program counter.
  `ASSERT_IMP(a_reload, clk_i, rst_ni, !empty && reload_pipeline_o, pc_write)
  // An undefined form writes nothing.
  `ASSERT_IMP(a_undef, clk_i, rst_ni, !empty && undefined_op_o, !write_enable_o && !reload_pipeline_o)
endmodule

bind thumb_alu_execute tae_checker u_tae_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .empty(empty), .pop(pop),
  .write_enable_o(write_enable_o), .dest_index_o(dest_index_o),
  .dest_value_o(dest_value_o), .reload_pipeline_o(reload_pipeline_o),
  .undefined_op_o(undefined_op_o)
);

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the compressed-ISA execute block against a predictor that tracks the
// register file and the NZCV flags. Directed instructions cover the edge
// cases, then random programs run with random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic        we;
    logic [3:0]  idx;
    logic [31:0] value;
    logic [3:0]  nzcv;
    logic        reload;
    logic        undef;
  } retire_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic [3:0]  kind_i = '0;
  logic [15:0] instruction_i = '0;
  logic        full, empty;
  logic        write_enable_o, flag_negative_o, flag_zero_o, flag_carry_o;
  logic        flag_overflow_o, reload_pipeline_o, undefined_op_o;
  logic [3:0]  dest_index_o;
  logic [31:0] dest_value_o;

  logic [31:0] arch_regs [16];
  logic [3:0]  arch_flags;
  retire_t     retire_queue [$];
  int unsigned mismatch_count = 0;
  int unsigned retired_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_cycles = 0;
  bit          long_hold_req = 1'b0;

  thumb_alu_execute i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .kind_i            (kind_i),
    .instruction_i     (instruction_i),
    .empty             (empty),
    .pop               (pop),
    .write_enable_o    (write_enable_o),
    .dest_index_o      (dest_index_o),
    .dest_value_o      (dest_value_o),
    .flag_negative_o   (flag_negative_o),
    .flag_zero_o       (flag_zero_o),
    .flag_carry_o      (flag_carry_o),
    .flag_overflow_o   (flag_overflow_o),
    .reload_pipeline_o (reload_pipeline_o),
    .undefined_op_o    (undefined_op_o)
  );

  // Clock generation.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Flag helpers for the predictor.
  function automatic logic [31:0] flag_add(logic [31:0] a, logic [31:0] b, logic cin);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b} + 33'(cin);
    arch_flags = {s[31], s[31:0] == 0, s[32], (~(a[31] ^ b[31])) & (a[31] ^ s[31])};
    return s[31:0];
  endfunction

  function automatic logic [31:0] flag_sub(logic [31:0] a, logic [31:0] b, logic cin);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, ~b} + 33'(cin);
    arch_flags = {s[31], s[31:0] == 0, s[32], (a[31] ^ b[31]) & (a[31] ^ s[31])};
    return s[31:0];
  endfunction

  function automatic void set_nz(logic [31:0] r);
    arch_flags[3] = r[31];
    arch_flags[2] = (r == 0);
  endfunction

  // Executes one instruction on the predicted state and returns its retirement.
  function automatic retire_t execute_instr(logic [3:0] kind, logic [15:0] op);
    retire_t     rt;
    logic [3:0]  hd, hs, rh;
    logic [2:0]  ra, rb, rc;
    logic [7:0]  imm8, n;
    logic [4:0]  m;
    logic [31:0] a, b, r, rhs, off;
    logic        c;
    rt = '0;
    ra = op[2:0]; rb = op[5:3]; rc = op[8:6]; rh = {1'b0, op[10:8]}; imm8 = op[7:0];
    hd = {op[7], op[2:0]}; hs = {op[6], op[5:3]};
    case (kind)
      tae_pkg::KIND_LO_ADD, tae_pkg::KIND_LO_SUB: begin
        rhs = op[10] ? 32'(rc) : arch_regs[rc];
        rt.value = (kind == tae_pkg::KIND_LO_ADD) ? flag_add(arch_regs[rb], rhs, 1'b0)
                                                  : flag_sub(arch_regs[rb], rhs, 1'b1);
        rt.we = 1'b1; rt.idx = {1'b0, ra};
      end
      tae_pkg::KIND_MOV_IMM: begin
        rt.value = 32'(imm8); set_nz(rt.value); rt.we = 1'b1; rt.idx = rh;
      end
      tae_pkg::KIND_CMP_IMM: r = flag_sub(arch_regs[rh], 32'(imm8), 1'b1);
      tae_pkg::KIND_ADD_IMM: begin
        rt.value = flag_add(arch_regs[rh], 32'(imm8), 1'b0); rt.we = 1'b1; rt.idx = rh;
      end
      tae_pkg::KIND_SUB_IMM: begin
        rt.value = flag_sub(arch_regs[rh], 32'(imm8), 1'b1); rt.we = 1'b1; rt.idx = rh;
      end
      tae_pkg::KIND_HI_ADD, tae_pkg::KIND_HI_CMP, tae_pkg::KIND_HI_MOV: begin
        if (!op[7] && !op[6]) begin
          rt.undef = 1'b1;
        end else if (kind == tae_pkg::KIND_HI_CMP) begin
          r = flag_sub(arch_regs[hd], arch_regs[hs], 1'b1);
        end else begin
          rt.value = (kind == tae_pkg::KIND_HI_ADD) ? arch_regs[hd] + arch_regs[hs]
                                                    : arch_regs[hs];
          if (hd == tae_pkg::REG_PC) begin
            rt.value[0] = 1'b0; rt.reload = 1'b1;
          end
          rt.we = 1'b1; rt.idx = hd;
        end
      end
      tae_pkg::KIND_SP_ADDR: begin
        rt.value = arch_regs[tae_pkg::REG_SP] + {22'd0, imm8, 2'b00};
        rt.we = 1'b1; rt.idx = rh;
      end
      tae_pkg::KIND_PC_ADDR: begin
        rt.value = {arch_regs[tae_pkg::REG_PC][31:2], 2'b00} + {22'd0, imm8, 2'b00};
        rt.we = 1'b1; rt.idx = rh;
      end
      tae_pkg::KIND_SP_ADJ: begin
        off = {23'd0, op[6:0], 2'b00};
        rt.value = op[7] ? arch_regs[tae_pkg::REG_SP] - off
                         : arch_regs[tae_pkg::REG_SP] + off;
        rt.we = 1'b1; rt.idx = tae_pkg::REG_SP;
      end
      tae_pkg::KIND_ALU: begin
        a = arch_regs[ra]; b = arch_regs[rb]; n = b[7:0]; c = arch_flags[1]; r = a;
        m = n[4:0]; rt.we = 1'b1; rt.idx = {1'b0, ra};
        case (op[9:6])
          tae_pkg::ALU_AND: begin r = a & b; set_nz(r); end
          tae_pkg::ALU_EOR: begin r = a ^ b; set_nz(r); end
          tae_pkg::ALU_LSL: begin
            if (n == 0) r = a;
            else if (n < 32) begin c = a[32 - n]; r = a << n; end
            else if (n == 32) begin c = a[0]; r = 0; end
            else begin c = 1'b0; r = 0; end
            arch_flags[1] = c; set_nz(r);
          end
          tae_pkg::ALU_LSR: begin
            if (n == 0) r = a;
            else if (n < 32) begin c = a[n - 1]; r = a >> n; end
            else if (n == 32) begin c = a[31]; r = 0; end
            else begin c = 1'b0; r = 0; end
            arch_flags[1] = c; set_nz(r);
          end
          tae_pkg::ALU_ASR: begin
            if (n == 0) r = a;
            else if (n < 32) begin c = a[n - 1]; r = $signed(a) >>> n; end
            else begin c = a[31]; r = {32{a[31]}}; end
            arch_flags[1] = c; set_nz(r);
          end
          tae_pkg::ALU_ADC: r = flag_add(a, b, c);
          tae_pkg::ALU_SBC: r = flag_sub(a, b, c);
          tae_pkg::ALU_ROR: begin
            if (n == 0) r = a;
            else if (m == 0) c = a[31];
            else begin c = a[m - 1]; r = (a >> m) | (a << (32 - m)); end
            arch_flags[1] = c; set_nz(r);
          end
          tae_pkg::ALU_TST: begin set_nz(a & b); rt.we = 1'b0; end
          tae_pkg::ALU_NEG: r = flag_sub(32'd0, b, 1'b1);
          tae_pkg::ALU_CMP: begin r = flag_sub(a, b, 1'b1); rt.we = 1'b0; end
          tae_pkg::ALU_CMN: begin r = flag_add(a, b, 1'b0); rt.we = 1'b0; end
          tae_pkg::ALU_ORR: begin r = a | b; set_nz(r); end
          tae_pkg::ALU_MUL: begin r = a * b; set_nz(r); end
          tae_pkg::ALU_BIC: begin r = a & ~b; set_nz(r); end
          default: begin r = ~b; set_nz(r); end
        endcase
        if (rt.we) rt.value = r;
        else rt.idx = '0;
      end
      default: ;
    endcase
    if (rt.we) arch_regs[rt.idx] = rt.value;
    rt.nzcv = arch_flags;
    return rt;
  endfunction

  // Draws an idle gap: mostly none or short, sometimes long.
  function automatic int unsigned idle_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offers one request and waits until it is accepted. Push stays high after
  // acceptance so that the next request can follow without a gap.
  task automatic send_instr(logic [3:0] kind, logic [15:0] op, bit may_idle = 1'b1);
    int unsigned gap;
    gap = may_idle ? idle_gap() : 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    kind_i <= kind;
    instruction_i <= op;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    retire_queue.push_back(execute_instr(kind, op));
  endtask

  // Stops offering and waits until every predicted result has come back.
  task automatic drain();
    push <= 1'b0;
    while (retire_queue.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random pop with optional long hold-off.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      pop <= 1'b0;
    end else if (long_hold_req) begin
      hold_cycles <= 60;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 99) < 30);
      if ($urandom_range(0, 199) == 0) hold_cycles <= $urandom_range(10, 40);
    end
  end

  // Result checker: compares each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    retire_t got, want;
    if (rst_ni && pop && !empty) begin
      got = {write_enable_o, dest_index_o, dest_value_o, flag_negative_o, flag_zero_o,
             flag_carry_o, flag_overflow_o, reload_pipeline_o, undefined_op_o};
      retired_count <= retired_count + 1;
      if (retire_queue.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < 10) $display("unexpected result %p", got);
      end else begin
        want = retire_queue.pop_front();
        if (got !== want) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) begin
            $display("mismatch: expected we=%b rd=%0d val=%h nzcv=%b rl=%b ud=%b",
                     want.we, want.idx, want.value, want.nzcv, want.reload, want.undef);
            $display("          got      we=%b rd=%0d val=%h nzcv=%b rl=%b ud=%b",
                     got.we, got.idx, got.value, got.nzcv, got.reload, got.undef);
          end
        end
      end
    end
  end

  // Loads a full 32-bit value into a low register through immediate moves and adds and shifts by r7.
  task automatic load_reg(logic [2:0] rd, logic [31:0] val);
    send_instr(tae_pkg::KIND_MOV_IMM, {5'b00100, rd, val[31:24]});
    for (int i = 2; i >= 0; i--) begin
      send_instr(tae_pkg::KIND_MOV_IMM, {5'b00100, 3'd7, 8'd8});
      send_instr(tae_pkg::KIND_ALU, {6'b010000, tae_pkg::ALU_LSL, 3'd7, rd});
      send_instr(tae_pkg::KIND_ADD_IMM, {5'b00110, rd, val[i*8 +: 8]});
    end
  endtask

  // Directed edge cases.
  task automatic test_directed();
    logic [3:0] k;
    load_reg(3'd0, 32'h8000_0000);
    load_reg(3'd1, 32'hFFFF_FFFF);
    send_instr(tae_pkg::KIND_LO_ADD, {7'b0001100, 3'd1, 3'd0, 3'd2});   // overflow/carry
    send_instr(tae_pkg::KIND_LO_SUB, {7'b0001111, 3'd7, 3'd0, 3'd2});   // immediate form
    send_instr(tae_pkg::KIND_CMP_IMM, {5'b00101, 3'd1, 8'hFF});
    send_instr(tae_pkg::KIND_SUB_IMM, {5'b00111, 3'd0, 8'h01});
    send_instr(tae_pkg::KIND_HI_ADD, 16'h4400);                         // both h bits clear
    send_instr(tae_pkg::KIND_HI_MOV, {8'h46, 1'b1, 1'b0, 3'd1, 3'd7});  // write to r15
    send_instr(tae_pkg::KIND_HI_ADD, {8'h44, 1'b1, 1'b1, 3'd5, 3'd5});  // SP += SP
    send_instr(tae_pkg::KIND_HI_CMP, {8'h45, 1'b1, 1'b1, 3'd7, 3'd5});
    send_instr(tae_pkg::KIND_SP_ADDR, {5'b10101, 3'd3, 8'hFF});
    send_instr(tae_pkg::KIND_PC_ADDR, {5'b10100, 3'd4, 8'hFF});
    send_instr(tae_pkg::KIND_SP_ADJ, {8'hB0, 1'b1, 7'h7F});
    for (int i = 0; i < 16; i++) begin
      send_instr(tae_pkg::KIND_ALU, {6'b010000, 4'(i), 3'd1, 3'd0});
    end
    for (k = 4'd13; k != 4'd0; k++) send_instr(k, 16'hFFFF);  // unused kinds
    drain();
  endtask

  // Shift amounts 0, 31, 32, 33 and 64 for every shift.
  task automatic test_shift_edges();
    logic [7:0] amounts [5] = '{8'd0, 8'd31, 8'd32, 8'd33, 8'd64};
    foreach (amounts[j]) begin
      send_instr(tae_pkg::KIND_MOV_IMM, {5'b00100, 3'd6, amounts[j]});
      send_instr(tae_pkg::KIND_ALU, {6'b010000, tae_pkg::ALU_LSL, 3'd6, 3'd1});
      send_instr(tae_pkg::KIND_ALU, {6'b010000, tae_pkg::ALU_LSR, 3'd6, 3'd0});
      send_instr(tae_pkg::KIND_ALU, {6'b010000, tae_pkg::ALU_ASR, 3'd6, 3'd2});
      send_instr(tae_pkg::KIND_ALU, {6'b010000, tae_pkg::ALU_ROR, 3'd6, 3'd3});
    end
    drain();
  endtask

  // Random programs, mostly valid kinds with random words.
  task automatic test_random(int unsigned count);
    logic [3:0] k;
    for (int i = 0; i < count; i++) begin
      k = ($urandom_range(0, 49) == 0) ? 4'($urandom_range(13, 15))
                                       : 4'($urandom_range(0, 12));
      send_instr(k, 16'($urandom));
    end
  endtask

  // Receiver stalls for a long stretch while requests keep coming.
  task automatic test_backpressure();
    drain();
    long_hold_req = 1'b1;
    wait (hold_cycles != 0);
    long_hold_req = 1'b0;
    repeat (10) send_instr(tae_pkg::KIND_ALU, 16'($urandom), 1'b0);
    drain();
  endtask

  initial begin
    foreach (arch_regs[i]) arch_regs[i] = '0;
    arch_flags = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_shift_edges();
    test_random(600);
    test_backpressure();
    test_random(600);
    drain();
    repeat (20) @(posedge clk_i);
    $display("covered all 13 instruction kinds, 16 ALU ops, shift edges and stalls;");
    $display("%0d results checked, %0d mismatches", retired_count, mismatch_count);
    if (mismatch_count == 0 && retire_queue.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/tae_pkg.sv
hw/rtl/tae_front.sv
hw/rtl/tae_queue.sv
hw/rtl/tae_back.sv
hw/rtl/thumb_alu_execute.sv
hw/rtl/tae_checker.sv
sim/testbench.sv
